FILE: design/tpps_pkg.sv
// Shared types, codes and constants of the timed pump drive with soft-start ramp.
package tpps_pkg;

  // Millisecond arithmetic
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned MS_W      = 42;   // holds 2^32 * 1000 + 2^32
  localparam int unsigned RUN_W     = 33;   // duration plus one millisecond

  // Configuration register reset values
  localparam logic [7:0] RAMP_PRESCALE_RST = 8'd9;
  localparam logic [7:0] BLINK_PERIOD_RST  = 8'd100;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PRESCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 1'b1;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_BLINK = 2'd2;

  // Input word as registered at the front
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_seconds;
    logic [7:0]  target_speed;
    logic [31:0] duration_ms;
    logic [1:0]  valve_select;
    logic [7:0]  blink_count;
  } in_word_t;

  // Word handed from the front stages to the core
  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      now_seconds;
    logic [7:0]       target_speed;
    logic [RUN_W-1:0] run_len_ms;
    logic [1:0]       valve_select;
    logic [7:0]       blink_count;
    logic [MS_W-1:0]  ms_base;      // now_seconds * 1000
  } stage_t;

  // Seconds to milliseconds
  function automatic logic [MS_W-1:0] sec_to_ms(input logic [31:0] sec);
    sec_to_ms = MS_W'(sec) * MS_W'(MS_PER_S);
  endfunction

endpackage

FILE: design/tpps_in_if.sv
// Input channel of the pump drive: valid/ready handshake and one command word.
interface tpps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_seconds;
  logic [7:0]  target_speed;
  logic [31:0] duration_ms;
  logic [1:0]  valve_select;
  logic [7:0]  blink_count;

  modport source (
    output valid, kind, now_seconds, target_speed, duration_ms, valve_select, blink_count,
    input  ready
  );
  modport sink (
    input  valid, kind, now_seconds, target_speed, duration_ms, valve_select, blink_count,
    output ready
  );
endinterface

FILE: design/tpps_out_if.sv
// Output channel of the pump drive: valid/ready handshake and one status word.
interface tpps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic [2:0] valves_open;
  logic       led_lit;
  logic       pump_free;

  modport source (
    output valid, duty, valves_open, led_lit, pump_free,
    input  ready
  );
  modport sink (
    input  valid, duty, valves_open, led_lit, pump_free,
    output ready
  );
endinterface

FILE: design/tpps_front.sv
// Front stages: input register, then seconds-to-milliseconds product register.
module tpps_front
  import tpps_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  tpps_in_if.sink in_if,
  output logic   stage_valid_o,
  input  logic   stage_ready_i,
  output stage_t stage_o
);

  logic     a_valid_q;
  in_word_t a_q;
  logic     a_ready;
  logic     b_valid_q;
  stage_t   b_q;
  logic     b_ready;
  stage_t   b_d;

  // Advance each stage when it is empty or its word moves on
  assign b_ready     = !b_valid_q || stage_ready_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign in_if.ready = a_ready;

  // Hold the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_if.valid) begin
      a_q.kind         <= in_if.kind;
      a_q.now_seconds  <= in_if.now_seconds;
      a_q.target_speed <= in_if.target_speed;
      a_q.duration_ms  <= in_if.duration_ms;
      a_q.valve_select <= in_if.valve_select;
      a_q.blink_count  <= in_if.blink_count;
    end
  end

  // Scale seconds to milliseconds and extend the run length
  always_comb begin
    b_d.kind         = a_q.kind;
    b_d.now_seconds  = a_q.now_seconds;
    b_d.target_speed = a_q.target_speed;
    b_d.run_len_ms   = RUN_W'(a_q.duration_ms) + RUN_W'(1);
    b_d.valve_select = a_q.valve_select;
    b_d.blink_count  = a_q.blink_count;
    b_d.ms_base      = sec_to_ms(a_q.now_seconds);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign stage_valid_o = b_valid_q;
  assign stage_o       = b_q;

endmodule

FILE: design/tpps_core.sv
// Pump state: run timer, duty ramp, valves, LED and blink logic, and the result register.
module tpps_core
  import tpps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  stage_valid_i,
  output logic                  stage_ready_o,
  input  stage_t                stage_i,
  tpps_out_if.source            out_if
);

  // Configuration
  logic [7:0] ramp_prescale_q;
  logic [7:0] blink_period_q;

  // Pump state, which is also the result word on display
  logic [7:0]      psc_q,     psc_d;
  logic [7:0]      duty_q,    duty_d;
  logic [7:0]      goal_q,    goal_d;
  logic [MS_W-1:0] end_ms_q,  end_ms_d;
  logic [MS_W-1:0] start_ms_q, start_ms_d;
  logic [31:0]     last_sec_q, last_sec_d;
  logic [15:0]     ms_q,      ms_d;
  logic [2:0]      valves_q,  valves_d;
  logic            free_q,    free_d;
  logic            led_q,     led_d;
  logic            led_clr_q, led_clr_d;
  logic [7:0]      blinks_q,  blinks_d;
  logic [7:0]      timer_q,   timer_d;
  logic            res_valid_q;

  logic            fire;
  logic [7:0]      psc_next;
  logic [MS_W-1:0] now_ms;
  logic            running;
  logic [2:0]      valve_dec;

  // Take a word when the result register is free or being drained
  assign stage_ready_o = !res_valid_q || out_if.ready;
  assign fire          = stage_valid_i && stage_ready_o;

  // Step the prescaler and compare the run end with the present time
  assign psc_next = (psc_q <= ramp_prescale_q) ? psc_q + 8'd1 : 8'd0;
  assign now_ms   = stage_i.ms_base + MS_W'(ms_q);
  assign running  = end_ms_q > now_ms;

  // Decode the valve select one-hot
  always_comb begin
    case (stage_i.valve_select)
      2'd1:    valve_dec = 3'b001;
      2'd2:    valve_dec = 3'b010;
      2'd3:    valve_dec = 3'b100;
      default: valve_dec = 3'b000;
    endcase
  end

  // Apply one word to the pump state
  always_comb begin
    psc_d      = psc_q;
    duty_d     = duty_q;
    goal_d     = goal_q;
    end_ms_d   = end_ms_q;
    start_ms_d = start_ms_q;
    last_sec_d = last_sec_q;
    ms_d       = ms_q;
    valves_d   = valves_q;
    free_d     = free_q;
    led_d      = led_q;
    led_clr_d  = led_clr_q;
    blinks_d   = blinks_q;
    timer_d    = timer_q;
    if (fire) begin
      case (stage_i.kind)
        KIND_TICK: begin
          psc_d = psc_next;
          if (running) begin
            // Ramp toward the goal and count milliseconds in this second
            if (duty_q < goal_q && psc_next == 8'd0) begin
              duty_d = duty_q + 8'd1;
            end else if (duty_q > goal_q) begin
              duty_d = duty_q - 8'd1;
            end
            if (stage_i.now_seconds != last_sec_q) begin
              last_sec_d = stage_i.now_seconds;
              ms_d       = 16'd1;
            end else begin
              ms_d = ms_q + 16'd1;
            end
          end else begin
            // Ramp down, then release the pump and close the valves
            if (duty_q != 8'd0 && psc_next == 8'd0) begin
              duty_d = duty_q - 8'd1;
            end
            if (duty_d == 8'd0) begin
              end_ms_d = start_ms_q;
              goal_d   = 8'd0;
              free_d   = 1'b1;
              valves_d = 3'b000;
            end
          end
          // LED follows the pump, cleared once when the duty returns to zero
          if (duty_d != 8'd0) begin
            led_d     = 1'b1;
            led_clr_d = 1'b0;
          end else if (led_q && !led_clr_q) begin
            led_d     = 1'b0;
            led_clr_d = 1'b1;
          end
          // Toggle the LED on the blink timer while the pump is free
          if (free_d && blinks_q != 8'd0) begin
            if (timer_q < blink_period_q) begin
              timer_d = timer_q + 8'd1;
            end else begin
              timer_d  = 8'd0;
              blinks_d = blinks_q - 8'd1;
              led_d    = !led_d;
            end
          end
        end
        KIND_START: begin
          start_ms_d = stage_i.ms_base;
          end_ms_d   = stage_i.ms_base + MS_W'(stage_i.run_len_ms);
          goal_d     = stage_i.target_speed;
          free_d     = 1'b0;
          valves_d   = valve_dec;
        end
        KIND_BLINK: begin
          blinks_d = stage_i.blink_count;
        end
        default: begin
        end
      endcase
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_prescale_q <= RAMP_PRESCALE_RST;
      blink_period_q  <= BLINK_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RAMP_PRESCALE: ramp_prescale_q <= cfg_data_i;
        CFG_BLINK_PERIOD:  blink_period_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Update pump state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psc_q       <= 8'd0;
      duty_q      <= 8'd0;
      goal_q      <= 8'd0;
      end_ms_q    <= '0;
      start_ms_q  <= '0;
      last_sec_q  <= 32'd0;
      ms_q        <= 16'd0;
      valves_q    <= 3'b000;
      free_q      <= 1'b1;
      led_q       <= 1'b0;
      led_clr_q   <= 1'b1;
      blinks_q    <= 8'd0;
      timer_q     <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      psc_q      <= psc_d;
      duty_q     <= duty_d;
      goal_q     <= goal_d;
      end_ms_q   <= end_ms_d;
      start_ms_q <= start_ms_d;
      last_sec_q <= last_sec_d;
      ms_q       <= ms_d;
      valves_q   <= valves_d;
      free_q     <= free_d;
      led_q      <= led_d;
      led_clr_q  <= led_clr_d;
      blinks_q   <= blinks_d;
      timer_q    <= timer_d;
      if (stage_ready_o) begin
        res_valid_q <= stage_valid_i;
      end
    end
  end

  // State only moves with a word, so it doubles as the held result
  assign out_if.valid       = res_valid_q;
  assign out_if.duty        = duty_q;
  assign out_if.valves_open = valves_q;
  assign out_if.led_lit     = led_q;
  assign out_if.pump_free   = free_q;

  // At most one valve open, and none while the pump is free
  a_valves_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(valves_q))
    else $error("more than one valve open");

  a_free_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q |-> valves_q == 3'b000)
    else $error("valve open while pump free");

  // A running duty means a busy pump with its LED lit
  a_duty_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q != 8'd0 |-> (!free_q && led_q))
    else $error("nonzero duty with free pump or dark LED");

  // The result word holds while no new word is taken
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(duty_q) && $stable(valves_q) && $stable(led_q) && $stable(free_q)))
    else $error("result changed without a word");

endmodule

FILE: design/timed_pump_pwm_soft_start.sv
// Top level of the timed pump drive with soft-start ramp.
//
//   channel   dir  handshake            word
//   in_if     in   valid/ready          kind, now_seconds, target_speed, duration_ms,
//                                       valve_select, blink_count
//   out_if    out  valid/ready          duty, valves_open, led_lit, pump_free
//   cfg       in   cfg_we_i, no ready   cfg_idx_i, cfg_data_i
//
// One word per cycle while the output is not stalled; each taken word passes through the
// input register, the milliseconds product register, then the pump state register
// that is also the result. The combinational state update closes the word-to-word loop.
// Reset is asynchronous, active low; it empties the pipeline and loads default state.
// A stalled output holds its word and stalls the stages behind it only as they fill.
module timed_pump_pwm_soft_start
  import tpps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tpps_in_if.sink               in_if,
  tpps_out_if.source            out_if
);

  logic   stage_valid;
  logic   stage_ready;
  stage_t stage;

  tpps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready),
    .stage_o       (stage)
  );

  tpps_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .stage_i       (stage),
    .out_if        (out_if)
  );

endmodule

FILE: dv/timed_pump_pwm_soft_start_checker.sv
// Status checker for the timed pump drive: tracks pump state per command word and compares results.
module timed_pump_pwm_soft_start_checker
  import tpps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tpps_in_if                    in_if,
  tpps_out_if                   out_if,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] duty;
    logic [2:0] valves_open;
    logic       led_lit;
    logic       pump_free;
  } status_t;

  // Expected status words, oldest first
  status_t status_q[$];
  int unsigned fails = 0;

  // Register copies
  logic [7:0] ramp_prescale;
  logic [7:0] blink_period;

  // Pump state
  logic [7:0]       presc_cnt;
  logic [7:0]       duty_cur;
  logic [7:0]       duty_goal;
  logic [RUN_W-1:0] run_ms;
  logic [31:0]      start_sec;
  logic [31:0]      seen_sec;
  logic [15:0]      ms_count;
  logic [2:0]       valves;
  logic             is_free;
  logic             led_on;
  logic             led_released;
  logic [7:0]       blinks;
  logic [7:0]       blink_tmr;

  // Apply one command word to the pump state and return the status it leaves
  function automatic status_t pump_step(in_word_t w);
    logic [MS_W-1:0] end_ms;
    logic [MS_W-1:0] now_ms;
    case (w.kind)
      KIND_TICK: begin
        // advance the prescaler; a limit of 255 lets it wrap through 8 bits
        if (presc_cnt <= ramp_prescale) presc_cnt = presc_cnt + 8'd1;
        else presc_cnt = '0;
        // compare at full width, no wrap
        end_ms = MS_W'(start_sec) * MS_W'(MS_PER_S) + MS_W'(run_ms);
        now_ms = MS_W'(w.now_seconds) * MS_W'(MS_PER_S) + MS_W'(ms_count);
        if (end_ms > now_ms) begin
          if (duty_cur < duty_goal && presc_cnt == 8'd0) duty_cur = duty_cur + 8'd1;
          else if (duty_cur > duty_goal) duty_cur = duty_cur - 8'd1;
          if (w.now_seconds != seen_sec) begin
            ms_count = '0;
            seen_sec = w.now_seconds;
          end
          ms_count = ms_count + 16'd1;
        end else begin
          // ramp down, then release the pump and close the valves
          if (duty_cur != 8'd0 && presc_cnt == 8'd0) duty_cur = duty_cur - 8'd1;
          if (duty_cur == 8'd0) begin
            run_ms    = '0;
            duty_goal = '0;
            is_free   = 1'b1;
            valves    = '0;
          end
        end
        // follow the duty with the LED; drop it once when the duty returns to zero
        if (duty_cur != 8'd0) begin
          led_on       = 1'b1;
          led_released = 1'b0;
        end else if (led_on && !led_released) begin
          led_on       = 1'b0;
          led_released = 1'b1;
        end
        // blink only while the pump is free
        if (is_free && blinks != 8'd0) begin
          if (blink_tmr < blink_period) begin
            blink_tmr = blink_tmr + 8'd1;
          end else begin
            blink_tmr = '0;
            blinks    = blinks - 8'd1;
            led_on    = !led_on;
          end
        end
      end
      KIND_START: begin
        run_ms    = RUN_W'(w.duration_ms) + RUN_W'(1);
        duty_goal = w.target_speed;
        is_free   = 1'b0;
        start_sec = w.now_seconds;
        valves    = (w.valve_select == 2'd0) ? 3'b000 : 3'b001 << (w.valve_select - 2'd1);
      end
      KIND_BLINK: begin
        blinks = w.blink_count;
      end
      default: begin
      end
    endcase
    return '{duty: duty_cur, valves_open: valves, led_lit: led_on, pump_free: is_free};
  endfunction

  // Track registers, predict on each accepted command, compare each accepted status
  always @(posedge clk_i or negedge rst_ni) begin : track
    in_word_t w;
    status_t  want;
    status_t  got;
    if (!rst_ni) begin
      ramp_prescale = RAMP_PRESCALE_RST;
      blink_period  = BLINK_PERIOD_RST;
      presc_cnt     = '0;
      duty_cur      = '0;
      duty_goal     = '0;
      run_ms        = '0;
      start_sec     = '0;
      seen_sec      = '0;
      ms_count      = '0;
      valves        = '0;
      is_free       = 1'b1;
      led_on        = 1'b0;
      led_released  = 1'b1;
      blinks        = '0;
      blink_tmr     = '0;
      status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RAMP_PRESCALE: ramp_prescale = cfg_data_i;
          CFG_BLINK_PERIOD:  blink_period  = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        w.kind         = in_if.kind;
        w.now_seconds  = in_if.now_seconds;
        w.target_speed = in_if.target_speed;
        w.duration_ms  = in_if.duration_ms;
        w.valve_select = in_if.valve_select;
        w.blink_count  = in_if.blink_count;
        status_q.push_back(pump_step(w));
      end
      if (out_if.valid && out_if.ready) begin
        got = '{duty: out_if.duty, valves_open: out_if.valves_open,
                led_lit: out_if.led_lit, pump_free: out_if.pump_free};
        if (status_q.size() == 0) begin
          $error("status word with none expected: duty %0d valves_open %0d led_lit %0d pump_free %0d",
                 got.duty, got.valves_open, got.led_lit, got.pump_free);
          fails++;
        end else begin
          want = status_q.pop_front();
          if (got.duty != want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, got.duty);
            fails++;
          end
          if (got.valves_open != want.valves_open) begin
            $error("valves_open: expected %0d, got %0d", want.valves_open, got.valves_open);
            fails++;
          end
          if (got.led_lit != want.led_lit) begin
            $error("led_lit: expected %0d, got %0d", want.led_lit, got.led_lit);
            fails++;
          end
          if (got.pump_free != want.pump_free) begin
            $error("pump_free: expected %0d, got %0d", want.pump_free, got.pump_free);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= status_q.size();
  end

endmodule

FILE: dv/timed_pump_pwm_soft_start_test.sv
// Top of the pump drive testbench: clock, reset, register writes, command stimulus and verdict.
module timed_pump_pwm_soft_start_test
  import tpps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 48;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned NUM_PHASES   = 8;

  typedef enum int unsigned {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tpps_in_if  cmd_if();
  tpps_out_if stat_if();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned sent          = 0;
  int unsigned presc_set     = 32'(RAMP_PRESCALE_RST);
  int unsigned period_set    = 32'(BLINK_PERIOD_RST);
  logic [31:0] cur_sec       = '0;

  timed_pump_pwm_soft_start u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (cmd_if),
    .out_if     (stat_if)
  );

  timed_pump_pwm_soft_start_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_if        (cmd_if),
    .out_if       (stat_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run
  initial begin
    #10_000_000;
    $display("timed_pump_pwm_soft_start_test failed");
    $finish;
  end

  // Status receiver: random stalls, plus a counted hold-off on request
  initial begin
    stat_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        stat_if.ready <= 1'b0;
        hold_left--;
      end else begin
        stat_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Offer one command word, with random gaps before it; valid stays up afterwards
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.kind         <= w.kind;
    cmd_if.now_seconds  <= w.now_seconds;
    cmd_if.target_speed <= w.target_speed;
    cmd_if.duration_ms  <= w.duration_ms;
    cmd_if.valve_select <= w.valve_select;
    cmd_if.blink_count  <= w.blink_count;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    w.kind         = 2'($urandom_range(0, 3));
    w.now_seconds  = $urandom();
    w.target_speed = 8'($urandom());
    w.duration_ms  = $urandom();
    w.valve_select = 2'($urandom_range(0, 3));
    w.blink_count  = 8'($urandom());
    return w;
  endfunction

  task automatic tick(input logic [31:0] sec);
    in_word_t w;
    w = noise_word();
    w.kind        = KIND_TICK;
    w.now_seconds = sec;
    send_word(w);
  endtask

  task automatic start_run(input logic [31:0] sec, input logic [7:0] tgt,
                           input logic [31:0] dur, input logic [1:0] sel);
    in_word_t w;
    w = noise_word();
    w.kind         = KIND_START;
    w.now_seconds  = sec;
    w.target_speed = tgt;
    w.duration_ms  = dur;
    w.valve_select = sel;
    send_word(w);
  endtask

  task automatic load_blinks(input logic [7:0] cnt);
    in_word_t w;
    w = noise_word();
    w.kind        = KIND_BLINK;
    w.blink_count = cnt;
    send_word(w);
  endtask

  // Drop valid, wait for every expected status word, then let the pipeline go quiet
  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back edges
  task automatic load_settings(input logic [7:0] presc, input logic [7:0] period);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RAMP_PRESCALE;
    cfg_data_i <= presc;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLINK_PERIOD;
    cfg_data_i <= period;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    presc_set  = 32'(presc);
    period_set = 32'(period);
  endtask

  // Start a watering run and tick it through ramp-up, hold and ramp-down
  task automatic water_run();
    int unsigned tgt;
    int unsigned n;
    int unsigned r;
    logic [31:0] dur;
    if (presc_set > 30) tgt = $urandom_range(0, 2);
    else if (presc_set <= 1 && $urandom_range(9) == 0) tgt = $urandom_range(0, 255);
    else tgt = $urandom_range(0, 12);
    dur = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(0, 60));
    start_run(cur_sec, 8'(tgt), dur, 2'($urandom_range(0, 3)));
    n = ((dur > 60) ? 40 : dur) + (tgt + 2) * (presc_set + 2) + $urandom_range(0, 8);
    if (n > 160) n = 160;
    repeat (n) begin
      r = $urandom_range(199);
      if (r < 2) cur_sec = cur_sec + 32'd1;
      else if (r < 4) send_word(noise_word());
      else if (r < 5) load_blinks(8'($urandom_range(0, 3)));
      tick(cur_sec);
    end
  endtask

  // Load a blink count and tick while it plays out
  task automatic blink_run();
    int unsigned cnt;
    int unsigned n;
    cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
    load_blinks(8'(cnt));
    n = ((cnt < 4) ? cnt : 4) * (period_set + 1) + $urandom_range(0, 5);
    if (n > 300) n = 300;
    repeat (n) tick(cur_sec);
  endtask

  initial begin : stimulus
    in_word_t    w;
    int unsigned goal;
    int unsigned r;
    bit          held;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_RAMP_PRESCALE;
    cfg_data_i          <= '0;
    cmd_if.valid        <= 1'b0;
    cmd_if.kind         <= KIND_TICK;
    cmd_if.now_seconds  <= '0;
    cmd_if.target_speed <= '0;
    cmd_if.duration_ms  <= '0;
    cmd_if.valve_select <= '0;
    cmd_if.blink_count  <= '0;
    held = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset settings
    tick(32'd0);
    w = '1;
    w.kind = KIND_UNUSED;
    send_word(w);
    load_blinks(8'd0);
    start_run(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 2'd3);
    tick(32'hFFFF_FFFF);
    tick(32'hFFFF_FFFF);
    tick(32'd0);
    start_run(32'd0, 8'd0, 32'd0, 2'd0);
    tick(32'd0);
    tick(32'd0);
    start_run(32'd7, 8'd1, 32'd2, 2'd1);
    repeat (3) tick(32'd7);
    start_run(32'd7, 8'd200, 32'd5, 2'd2);
    tick(32'd6);
    tick(32'd8);
    load_blinks(8'hFF);
    tick(32'd8);
    w = '0;
    w.kind = KIND_UNUSED;
    send_word(w);
    tick(32'd8);

    // Random phases, each with its own idling and register settings
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (idle_mode_e'(p % 4))
        IDLE_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        IDLE_SRC:  begin src_idle_pct = 86; snk_stall_pct = 0;  end
        IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 86; end
        default:   begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
      case (p)
        0:       load_settings(8'd0, 8'd0);
        1:       load_settings(8'd1, 8'd255);
        2:       load_settings(8'($urandom_range(2, 5)), 8'd5);
        3:       load_settings(8'd3, 8'd1);
        4:       load_settings(8'd255, 8'd100);
        5:       load_settings(8'd2, 8'($urandom_range(0, 20)));
        6:       load_settings(8'($urandom_range(0, 6)), 8'd2);
        default: load_settings(8'd0, 8'd255);
      endcase
      cur_sec = ($urandom_range(7) == 0) ? 32'hFFFF_FFF0 + 32'($urandom_range(0, 15))
                                         : $urandom();

      goal = sent + PHASE_ITEMS;
      if (p == 4) begin
        // slow prescaler that wraps through 8 bits: one step up, then one step down
        start_run(cur_sec, 8'd1, 32'd300, 2'd1);
        repeat (560) tick(cur_sec);
      end

      while (sent < goal) begin
        // hold off the receiver while commands keep coming
        if (p == 0 && !held && sent + PHASE_ITEMS / 2 > goal) begin
          hold_left = HOLD_CYCLES;
          held      = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 70) water_run();
        else if (r < 85) blink_run();
        else repeat ($urandom_range(1, 4)) send_word(noise_word());
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("timed_pump_pwm_soft_start_test passed");
    end else begin
      $display("timed_pump_pwm_soft_start_test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tpps_pkg.sv
design/tpps_in_if.sv
design/tpps_out_if.sv
design/tpps_front.sv
design/tpps_core.sv
design/timed_pump_pwm_soft_start.sv
dv/timed_pump_pwm_soft_start_checker.sv
dv/timed_pump_pwm_soft_start_test.sv
